// ===== rtl/multi_slot_tick_timer_bank_top_macros.svh =====
// Assertion macros used by the timer bank top level.
`ifndef MULTI_SLOT_TICK_TIMER_BANK_TOP_MACROS_SVH
`define MULTI_SLOT_TICK_TIMER_BANK_TOP_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define MSTB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence that must hold in the clock after the antecedent.
`define MSTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mstb_pkg.sv =====
// Package with the sizes, codes and shared types of the timer bank.
package mstb_pkg;

  localparam int NUM_SLOTS    = 16;
  localparam int IDX_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MAX_RESULTS  = 16;
  localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
  localparam int COUNT_W      = 30;
  localparam int SLOT_FIELD_W = 4;
  localparam int FUNC_W       = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_ARM  = 2'd1,
    FUNC_STOP = 2'd2
  } func_e;

  localparam logic STATUS_OK = 1'b0;

  typedef struct packed {
    logic                    arm;
    logic                    stop;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [COUNT_W-1:0]      timeout;
    logic                    act;
    logic                    rep;
  } wr_t;

  typedef struct packed {
    logic start;
    logic adv;
  } scan_ctl_t;

endpackage

// ===== rtl/mstb_req_if.sv =====
// Request channel interface of the timer bank.
interface mstb_req_if;
  logic                                valid;
  logic                                ready;
  logic [mstb_pkg::FUNC_W-1:0]         func;
  logic [mstb_pkg::SLOT_FIELD_W-1:0]   slot;
  logic [mstb_pkg::COUNT_W-1:0]        timeout;
  logic                                start_active;
  logic                                repeat_req;

  modport source (output valid, func, slot, timeout, start_active, repeat_req, input ready);
  modport sink (input valid, func, slot, timeout, start_active, repeat_req, output ready);
endinterface

// ===== rtl/mstb_res_if.sv =====
// Result channel interface of the timer bank.
interface mstb_res_if;
  logic                              valid;
  logic                              ready;
  logic                              fired;
  logic [mstb_pkg::SLOT_FIELD_W-1:0] fired_slot;
  logic                              status;
  logic                              last;

  modport source (output valid, fired, fired_slot, status, last, input ready);
  modport sink (input valid, fired, fired_slot, status, last, output ready);
endinterface

// ===== rtl/mstb_cell.sv =====
// One timer slot cell: holds the slot state and passes the scan token on.
module mstb_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [mstb_pkg::COUNT_W-1:0] tick_step_i,
  input  mstb_pkg::scan_ctl_t        scan_i,
  input  mstb_pkg::wr_t              wr_i,
  input  logic                       sel_i,
  input  logic                       tok_i,
  output logic                       tok_o,
  output logic                       fire_o
);
  import mstb_pkg::*;

  logic               tok_q;
  logic               en_q;
  logic               cyc_q;
  logic [COUNT_W-1:0] rem_q;
  logic [COUNT_W-1:0] reload_q;
  logic               hit;
  logic               upd;

  assign hit    = rem_q < tick_step_i;
  assign upd    = tok_q & scan_i.adv & en_q;
  assign fire_o = tok_q & en_q & hit;
  assign tok_o  = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      en_q  <= 1'b0;
      cyc_q <= 1'b0;
    end else begin
      if (scan_i.adv) begin
        tok_q <= tok_i;
      end
      if (sel_i && wr_i.arm) begin
        en_q  <= wr_i.act;
        cyc_q <= wr_i.rep;
      end else if (sel_i && wr_i.stop) begin
        en_q <= 1'b0;
      end else if (upd && hit && !cyc_q) begin
        en_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_i && wr_i.arm) begin
      rem_q    <= wr_i.timeout;
      reload_q <= wr_i.timeout;
    end else if (upd) begin
      rem_q <= (hit && cyc_q) ? reload_q : rem_q - tick_step_i;
    end
  end

endmodule

// ===== rtl/mstb_ctrl.sv =====
// Sequencer: takes requests, drives the token scan and orders the results.
module mstb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  mstb_req_if.sink            req_i,
  mstb_res_if.source          res_o,
  input  logic                fire_i,
  output mstb_pkg::wr_t       wr_o,
  output mstb_pkg::scan_ctl_t scan_o
);
  import mstb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINAL
  } state_e;

  typedef struct packed {
    logic                    fired;
    logic [SLOT_FIELD_W-1:0] fired_slot;
    logic                    status;
    logic                    last;
  } res_t;

  state_e                  state_q;
  logic [IDX_W-1:0]        idx_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    pend_v_q;
  logic [SLOT_FIELD_W-1:0] pend_slot_q;
  logic                    out_v_q;
  logic                    out_v_d;
  res_t                    out_q;

  logic                    push_ok;
  logic                    out_push;
  logic                    acc;
  logic                    in_range;
  logic                    rec;
  logic [IDX_W+SLOT_FIELD_W-1:0] idx_ext;

  assign push_ok  = !out_v_q || res_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && push_ok;
  assign acc      = req_i.valid && req_i.ready;
  assign in_range = int'(req_i.slot) < NUM_SLOTS;
  assign rec      = fire_i && (cnt_q < CNT_W'(MAX_RESULTS));
  assign idx_ext  = {{SLOT_FIELD_W{1'b0}}, idx_q};

  assign wr_o.arm     = acc && (req_i.func == FUNC_ARM) && in_range;
  assign wr_o.stop    = acc && (req_i.func == FUNC_STOP) && in_range;
  assign wr_o.slot    = req_i.slot;
  assign wr_o.timeout = req_i.timeout;
  assign wr_o.act     = req_i.start_active;
  assign wr_o.rep     = req_i.repeat_req;

  assign scan_o.start = acc && (req_i.func == FUNC_TICK);
  assign scan_o.adv   = scan_o.start ||
                        ((state_q == S_SCAN) && !(rec && pend_v_q && !push_ok));

  assign out_push = ((state_q == S_IDLE) && acc && (req_i.func != FUNC_TICK)) ||
                    ((state_q == S_SCAN) && scan_o.adv && rec && pend_v_q) ||
                    ((state_q == S_FINAL) && push_ok);
  assign out_v_d  = out_push || (out_v_q && !res_o.ready);

  assign res_o.valid      = out_v_q;
  assign res_o.fired      = out_q.fired;
  assign res_o.fired_slot = out_q.fired_slot;
  assign res_o.status     = out_q.status;
  assign res_o.last       = out_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      pend_v_q    <= 1'b0;
      pend_slot_q <= '0;
      out_v_q     <= 1'b0;
      out_q       <= '0;
    end else begin
      out_v_q <= out_v_d;
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (req_i.func == FUNC_TICK) begin
              state_q  <= S_SCAN;
              idx_q    <= '0;
              cnt_q    <= '0;
              pend_v_q <= 1'b0;
            end else begin
              out_q   <= '{fired: 1'b0, fired_slot: '0, status: STATUS_OK, last: 1'b1};
            end
          end
        end
        S_SCAN: begin
          if (scan_o.adv) begin
            if (rec) begin
              if (pend_v_q) begin
                out_q   <= '{fired: 1'b1, fired_slot: pend_slot_q, status: STATUS_OK,
                             last: 1'b0};
              end
              pend_v_q    <= 1'b1;
              pend_slot_q <= idx_ext[SLOT_FIELD_W-1:0];
              cnt_q       <= cnt_q + CNT_W'(1);
            end
            if (idx_q == IDX_W'(NUM_SLOTS - 1)) begin
              state_q <= S_FINAL;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end
        end
        S_FINAL: begin
          if (push_ok) begin
            out_q   <= '{fired: pend_v_q, fired_slot: pend_v_q ? pend_slot_q : '0,
                         status: STATUS_OK, last: 1'b1};
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/multi_slot_tick_timer_bank_top.sv =====
// Top level of the timer bank: slot cell chain, sequencer and step register.
//
//   Channel   Dir  Handshake     Carries
//   req_i     in   valid/ready   func, slot, timeout, start_active, repeat_req
//   res_o     out  valid/ready   fired, fired_slot, status, last
//   tick_step in   write enable  tick_step_i, taken when tick_step_we_i is high
//
// An arm, stop or unused request yields a registered result, valid in the cycle after it is taken.
// A tick request walks a token down the sixteen cells, one cell per cycle while the
// result channel does not stall the scan; a final state then hands on the last result.
// A cell holding the token waits while a found expiry cannot be handed on.
// Reset clears the enable and cyclic bits; counts are undefined until armed.
`include "multi_slot_tick_timer_bank_top_macros.svh"

module multi_slot_tick_timer_bank_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mstb_req_if.sink                     req_i,
  mstb_res_if.source                   res_o,
  input  logic                         tick_step_we_i,
  input  logic [mstb_pkg::COUNT_W-1:0] tick_step_i
);
  import mstb_pkg::*;

  logic [COUNT_W-1:0]   tick_step_q;
  wr_t                  wr;
  scan_ctl_t            scan;
  logic [NUM_SLOTS-1:0] sel;
  logic [NUM_SLOTS-1:0] tok;
  logic [NUM_SLOTS-1:0] fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_step_q <= COUNT_W'(1);
    end else if (tick_step_we_i) begin
      tick_step_q <= tick_step_i;
    end
  end

  mstb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .res_o  (res_o),
    .fire_i (|fire),
    .wr_o   (wr),
    .scan_o (scan)
  );

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    logic tok_in;
    assign sel[g] = int'(wr.slot) == g;
    if (g == 0) begin : g_head
      assign tok_in = scan.start;
    end else begin : g_body
      assign tok_in = tok[g-1];
    end
    mstb_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tick_step_i (tick_step_q),
      .scan_i      (scan),
      .wr_i        (wr),
      .sel_i       (sel[g]),
      .tok_i       (tok_in),
      .tok_o       (tok[g]),
      .fire_o      (fire[g])
    );
  end

  `MSTB_ASSERT_ALWAYS(a_tok_single, $onehot0(tok), "more than one cell holds the scan token")
  `MSTB_ASSERT_NEXT(a_tok_start, scan.start, $onehot(tok), "tick did not place a scan token")
  `MSTB_ASSERT_NEXT(a_tok_leave, scan.adv && tok[NUM_SLOTS-1], tok == '0,
    "scan token did not leave the last cell")

endmodule

// ===== bench/multi_slot_tick_timer_bank_top_tb.sv =====
// Self-checking testbench for the timer bank: directed, tick step extremes, backpressure and random request traffic.
`timescale 1ns / 100ps

module multi_slot_tick_timer_bank_top_tb;
  import mstb_pkg::*;

  localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 30'h3FFF_FFFF;
  localparam int SETTLE_CYCLES = NUM_SLOTS + 4;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [COUNT_W-1:0]      timeout;
    logic                    start_active;
    logic                    repeat_req;
  } timer_request_t;

  typedef struct packed {
    logic                    fired;
    logic [SLOT_FIELD_W-1:0] fired_slot;
    logic                    status;
    logic                    last;
  } timer_event_t;

  logic clk;
  logic rst_n;
  logic step_we;
  logic [COUNT_W-1:0] step_data;

  mstb_req_if req_bus ();
  mstb_res_if res_bus ();

  multi_slot_tick_timer_bank_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .req_i          (req_bus),
    .res_o          (res_bus),
    .tick_step_we_i (step_we),
    .tick_step_i    (step_data)
  );

  logic [COUNT_W-1:0] model_step;
  logic [COUNT_W-1:0] model_remaining [NUM_SLOTS];
  logic [COUNT_W-1:0] model_reload [NUM_SLOTS];
  logic               model_enabled [NUM_SLOTS];
  logic               model_cyclic [NUM_SLOTS];

  timer_event_t expected_events [$];
  int unsigned  mismatch_count = 0;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_request_len;
  int unsigned  hold_requested;
  int unsigned  hold_served = 0;
  int unsigned  hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic timer_event_t make_event(logic fired, logic [SLOT_FIELD_W-1:0] slot,
                                              logic last);
    timer_event_t e;
    e.fired = fired;
    e.fired_slot = slot;
    e.status = STATUS_OK;
    e.last = last;
    return e;
  endfunction

  function automatic void predict_timer_bank(timer_request_t r);
    int unsigned fired_slots [$];
    logic [COUNT_W-1:0] old;
    case (r.func)
      FUNC_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (model_enabled[i]) begin
            old = model_remaining[i];
            if (old < model_step) begin
              if (model_cyclic[i]) begin
                model_remaining[i] = model_reload[i];
              end else begin
                model_remaining[i] = old - model_step;
                model_enabled[i] = 1'b0;
              end
              if (fired_slots.size() < MAX_RESULTS) fired_slots.push_back(i);
            end else begin
              model_remaining[i] = old - model_step;
            end
          end
        end
        if (fired_slots.size() == 0) begin
          expected_events.push_back(make_event(1'b0, '0, 1'b1));
        end else begin
          foreach (fired_slots[k]) begin
            expected_events.push_back(make_event(1'b1, fired_slots[k][SLOT_FIELD_W-1:0],
                                                 k == fired_slots.size() - 1));
          end
        end
      end
      FUNC_ARM: begin
        if (r.slot < NUM_SLOTS) begin
          model_reload[r.slot] = r.timeout;
          model_remaining[r.slot] = r.timeout;
          model_enabled[r.slot] = r.start_active;
          model_cyclic[r.slot] = r.repeat_req;
        end
        expected_events.push_back(make_event(1'b0, '0, 1'b1));
      end
      FUNC_STOP: begin
        if (r.slot < NUM_SLOTS) model_enabled[r.slot] = 1'b0;
        expected_events.push_back(make_event(1'b0, '0, 1'b1));
      end
      default: begin
        expected_events.push_back(make_event(1'b0, '0, 1'b1));
      end
    endcase
  endfunction

  always @(posedge clk) begin
    timer_request_t seen;
    timer_event_t got;
    timer_event_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        model_remaining[i] = '0;
        model_reload[i] = '0;
        model_enabled[i] = 1'b0;
        model_cyclic[i] = 1'b0;
      end
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        seen.func = req_bus.func;
        seen.slot = req_bus.slot;
        seen.timeout = req_bus.timeout;
        seen.start_active = req_bus.start_active;
        seen.repeat_req = req_bus.repeat_req;
        predict_timer_bank(seen);
      end
      if (res_bus.valid && res_bus.ready) begin
        got.fired = res_bus.fired;
        got.fired_slot = res_bus.fired_slot;
        got.status = res_bus.status;
        got.last = res_bus.last;
        if (expected_events.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("Unexpected result at %0t: fired=%b slot=%0d status=%b last=%b",
                     $realtime, got.fired, got.fired_slot, got.status, got.last);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display({"Mismatch at %0t: expected fired=%b slot=%0d status=%b last=%b,",
                        " got fired=%b slot=%0d status=%b last=%b"}, $realtime,
                       want.fired, want.fired_slot, want.status, want.last,
                       got.fired, got.fired_slot, got.status, got.last);
          end
        end
      end
    end
  end

  // The receiver either holds off for a counted stretch or stalls at random.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      res_bus.ready <= 1'b0;
    end else if (hold_served != hold_requested) begin
      hold_served++;
      hold_left = hold_request_len - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_request(input timer_request_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.func <= r.func;
    req_bus.slot <= r.slot;
    req_bus.timeout <= r.timeout;
    req_bus.start_active <= r.start_active;
    req_bus.repeat_req <= r.repeat_req;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
  endtask

  task automatic send_fields(input logic [FUNC_W-1:0] func, input int unsigned slot,
                             input logic [COUNT_W-1:0] timeout, input logic act,
                             input logic rep);
    timer_request_t r;
    r.func = func;
    r.slot = SLOT_FIELD_W'(slot);
    r.timeout = timeout;
    r.start_active = act;
    r.repeat_req = rep;
    send_request(r);
  endtask

  task automatic wait_until_drained();
    req_bus.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_step(input logic [COUNT_W-1:0] value);
    step_we <= 1'b1;
    step_data <= value;
    @(posedge clk);
    model_step = value;
    step_we <= 1'b0;
  endtask

  function automatic timer_request_t random_request();
    timer_request_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.slot = SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1));
    r.start_active = ($urandom_range(0, 99) < 85);
    r.repeat_req = 1'($urandom_range(0, 1));
    r.timeout = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom) :
                                              COUNT_W'($urandom_range(0, 12));
    if (pick < 45) r.func = FUNC_TICK;
    else if (pick < 85) r.func = FUNC_ARM;
    else if (pick < 95) r.func = FUNC_STOP;
    else r.func = FUNC_UNUSED;
    return r;
  endfunction

  task automatic test_directed();
    send_fields(FUNC_ARM, 0, '0, 1'b1, 1'b0);
    send_fields(FUNC_ARM, 15, COUNT_MAX, 1'b1, 1'b1);
    send_fields(FUNC_ARM, 10, 30'd1, 1'b1, 1'b1);
    send_fields(FUNC_ARM, 5, 30'd2, 1'b0, 1'b1);
    send_fields(FUNC_TICK, 0, '0, 1'b0, 1'b0);
    send_fields(FUNC_TICK, 0, '0, 1'b0, 1'b0);
    send_fields(FUNC_TICK, 0, '0, 1'b0, 1'b0);
    send_fields(FUNC_STOP, 10, '0, 1'b0, 1'b0);
    send_fields(FUNC_TICK, 15, COUNT_MAX, 1'b1, 1'b1);
    send_fields(FUNC_UNUSED, 15, COUNT_MAX, 1'b1, 1'b1);
    send_fields(FUNC_STOP, 0, '0, 1'b0, 1'b0);
    send_fields(FUNC_STOP, 15, '0, 1'b0, 1'b0);
    send_fields(FUNC_ARM, 5, '0, 1'b1, 1'b0);
    send_fields(FUNC_TICK, 0, '0, 1'b0, 1'b0);
    wait_until_drained();
  endtask

  task automatic test_tick_step_extremes();
    write_tick_step('0);
    send_fields(FUNC_ARM, 2, '0, 1'b1, 1'b1);
    send_fields(FUNC_TICK, 0, '0, 1'b0, 1'b0);
    send_fields(FUNC_TICK, 0, '0, 1'b0, 1'b0);
    wait_until_drained();
    write_tick_step(COUNT_MAX);
    send_fields(FUNC_TICK, 0, '0, 1'b0, 1'b0);
    send_fields(FUNC_ARM, 3, COUNT_MAX, 1'b1, 1'b1);
    send_fields(FUNC_ARM, 4, COUNT_MAX - 1, 1'b1, 1'b0);
    send_fields(FUNC_TICK, 0, '0, 1'b0, 1'b0);
    send_fields(FUNC_TICK, 0, '0, 1'b0, 1'b0);
    send_fields(FUNC_STOP, 2, '0, 1'b0, 1'b0);
    send_fields(FUNC_STOP, 3, '0, 1'b0, 1'b0);
    wait_until_drained();
    write_tick_step(30'd1);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < NUM_SLOTS; i++) send_fields(FUNC_ARM, i, '0, 1'b1, 1'b1);
    wait_until_drained();
    hold_request_len = 300;
    hold_requested++;
    repeat (6) send_fields(FUNC_TICK, 0, '0, 1'b0, 1'b0);
    wait_until_drained();
    for (int i = 0; i < NUM_SLOTS; i++) send_fields(FUNC_STOP, i, '0, 1'b0, 1'b0);
    wait_until_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned idle_pcts [4] = '{0, 87, 0, 31};
    int unsigned stall_pcts [4] = '{0, 0, 87, 31};
    for (int p = 0; p < 4; p++) begin
      wait_until_drained();
      write_tick_step((p == 0) ? 30'd1 : 30'($urandom_range(1, 3)));
      send_idle_pct = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      repeat (35) send_request(random_request());
    end
    wait_until_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.func <= FUNC_TICK;
    req_bus.slot <= '0;
    req_bus.timeout <= '0;
    req_bus.start_active <= 1'b0;
    req_bus.repeat_req <= 1'b0;
    step_we <= 1'b0;
    step_data <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request_len = 0;
    hold_requested = 0;
    model_step = 30'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_tick_step_extremes();
    test_backpressure();
    test_random_traffic();
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
